[sv/nearest_owned_neighbor_force_add_macros.svh]
// Assertion macros shared by the nearest owned neighbour force add RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef NEAREST_OWNED_NEIGHBOR_FORCE_ADD_MACROS_SVH
`define NEAREST_OWNED_NEIGHBOR_FORCE_ADD_MACROS_SVH

`ifndef ASSERT_OFF

// Condition implies consequence in the same cycle
`define NONFA_ASSERT_IMPL(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle
`define NONFA_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`else

`define NONFA_ASSERT_IMPL(lbl, clk, rst, cond, cons, msg)
`define NONFA_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg)

`endif

`endif

[sv/nonfa_pkg.sv]
// Shared types, widths and helpers for the nearest owned neighbour force add block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package nonfa_pkg;

  localparam int IdW    = 16;
  localparam int PosW   = 24;
  localparam int ForceW = 32;
  localparam int RadW   = 24;
  localparam int DiffW  = 24;  // magnitude of a difference of two Q12.12 positions
  localparam int SqW    = 2 * DiffW;
  localparam int DistW  = SqW + 2;  // sum of three squares

  localparam int QUEUE_DEPTH = 4;

  localparam logic [RadW-1:0] RADIUS_RESET = RadW'(4096);
  localparam logic [SqW-1:0]  RADSQ_RESET  = SqW'(RADIUS_RESET) * SqW'(RADIUS_RESET);

  typedef enum logic {
    CMD_START    = 1'b0,
    CMD_NEIGHBOR = 1'b1
  } cmd_t;

  // One classified request passed from front to back
  typedef struct packed {
    cmd_t                         cmd;
    logic                         qual;
    logic                         last;
    logic [2:0][DiffW-1:0]        diff;
    logic [2:0][ForceW-1:0]       frc;
  } entry_t;

  // Signed add clamped to the 32-bit range
  function automatic logic [ForceW-1:0] sat_add(input logic [ForceW-1:0] a,
                                                input logic [ForceW-1:0] b);
    logic [ForceW:0] s;
    logic [ForceW-1:0] r;
    s = {a[ForceW-1], a} + {b[ForceW-1], b};
    if (s[ForceW] != s[ForceW-1]) begin
      r = s[ForceW] ? {1'b1, {(ForceW-1){1'b0}}} : {1'b0, {(ForceW-1){1'b1}}};
    end else begin
      r = s[ForceW-1:0];
    end
    return r;
  endfunction

endpackage

[sv/nonfa_front.sv]
// Front end: accepts requests, tracks the node id and position, classifies
// neighbours and forms per-axis distance magnitudes. Depends on nonfa_pkg.
`timescale 1ns / 1ps
`include "nearest_owned_neighbor_force_add_macros.svh"

module nonfa_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [nonfa_pkg::IdW-1:0]    owner_id,
  input  logic [nonfa_pkg::PosW-1:0]   pos_x,
  input  logic [nonfa_pkg::PosW-1:0]   pos_y,
  input  logic [nonfa_pkg::PosW-1:0]   pos_z,
  input  logic [nonfa_pkg::ForceW-1:0] force_x,
  input  logic [nonfa_pkg::ForceW-1:0] force_y,
  input  logic [nonfa_pkg::ForceW-1:0] force_z,
  input  logic                         is_attached,
  input  logic                         is_active,
  input  logic                         last_item,
  output logic                         ent_valid,
  output nonfa_pkg::entry_t            ent,
  input  logic                         q_full
);

  logic                                 f_valid;
  logic [nonfa_pkg::IdW-1:0]            node_id;
  logic [2:0][nonfa_pkg::PosW-1:0]      node_pos;
  logic [2:0][nonfa_pkg::PosW-1:0]      pos_in;
  nonfa_pkg::entry_t                    ent_next;
  nonfa_pkg::cmd_t                      cmd_in;
  logic                                 accept;
  logic                                 push;

  assign cmd_in = nonfa_pkg::cmd_t'(command);
  assign pos_in = {pos_z, pos_y, pos_x};

  // Hold the stage while the queue is full
  assign push      = f_valid && !q_full;
  assign in_stall  = f_valid && q_full;
  assign accept    = in_valid && !in_stall;
  assign ent_valid = f_valid;

  // Classify and form absolute axis differences
  always_comb begin
    logic signed [nonfa_pkg::PosW:0] d;
    ent_next.cmd  = cmd_in;
    ent_next.last = last_item;
    ent_next.qual = (owner_id == node_id) && is_attached && is_active;
    ent_next.frc  = {force_z, force_y, force_x};
    for (int i = 0; i < 3; i++) begin
      d = $signed({pos_in[i][nonfa_pkg::PosW-1], pos_in[i]}) -
          $signed({node_pos[i][nonfa_pkg::PosW-1], node_pos[i]});
      ent_next.diff[i] = d[nonfa_pkg::PosW] ? nonfa_pkg::DiffW'(-d)
                                            : nonfa_pkg::DiffW'(d);
    end
  end

  // Advance the stage and load node data on a start
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid  <= 1'b0;
      node_id  <= '0;
      node_pos <= '0;
    end else begin
      if (accept) begin
        f_valid <= 1'b1;
      end else if (push) begin
        f_valid <= 1'b0;
      end
      if (accept && cmd_in == nonfa_pkg::CMD_START) begin
        node_id  <= owner_id;
        node_pos <= pos_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent <= ent_next;
    end
  end

  `NONFA_ASSERT_IMPL(a_front_stall_held, clk, rst, in_stall, f_valid && !push,
                     "front stalls without a held request")

endmodule

[sv/nonfa_queue.sv]
// Short FIFO of classified requests between front and back.
// Depends on nonfa_pkg for the entry type.
`timescale 1ns / 1ps
`include "nearest_owned_neighbor_force_add_macros.svh"

module nonfa_queue #(
  parameter int Depth = nonfa_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  nonfa_pkg::entry_t push_ent,
  output logic              full,
  output logic              q_valid,
  output nonfa_pkg::entry_t q_ent,
  input  logic              pop
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  nonfa_pkg::entry_t slots [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full    = (count == CntW'(Depth));
  assign q_valid = (count != '0);
  assign q_ent   = slots[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

  `NONFA_ASSERT_IMPL(a_q_no_overflow, clk, rst, push, !full, "push into full queue")
  `NONFA_ASSERT_IMPL(a_q_no_underflow, clk, rst, pop, q_valid, "pop from empty queue")

endmodule

[sv/nonfa_back.sv]
// Back end: squares the axis differences, keeps the nearest qualifying force,
// and emits the saturated sum. Depends on nonfa_pkg.
`timescale 1ns / 1ps
`include "nearest_owned_neighbor_force_add_macros.svh"

module nonfa_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [nonfa_pkg::RadW-1:0]   cfg_wr_data,
  input  logic                         q_valid,
  input  nonfa_pkg::entry_t            q_ent,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nonfa_pkg::ForceW-1:0] total_x,
  output logic [nonfa_pkg::ForceW-1:0] total_y,
  output logic [nonfa_pkg::ForceW-1:0] total_z,
  output logic                         neighbor_found
);

  localparam int DistW  = nonfa_pkg::DistW;
  localparam int SqW    = nonfa_pkg::SqW;
  localparam int ForceW = nonfa_pkg::ForceW;

  logic [SqW-1:0]              rad_sq;
  logic [ForceW*3-1:0]         unused_pad;

  // Squaring stage
  logic                        s1_valid;
  nonfa_pkg::cmd_t             s1_cmd;
  logic                        s1_qual;
  logic                        s1_last;
  logic [2:0][SqW-1:0]         s1_sq;
  logic [2:0][ForceW-1:0]      s1_frc;
  logic                        s1_fire;
  logic                        out_free;

  // Search state
  logic [2:0][ForceW-1:0]      node_frc;
  logic [DistW-1:0]            best_dist_sq;
  logic [2:0][ForceW-1:0]      best_frc;
  logic                        found_flag;

  logic [DistW-1:0]            d2;
  logic [2:0][ForceW-1:0]      nf_eff;
  logic [DistW-1:0]            bd_eff;
  logic [2:0][ForceW-1:0]      bf_eff;
  logic                        fd_eff;
  logic [DistW-1:0]            best_dist_sq_next;
  logic [2:0][ForceW-1:0]      best_frc_next;
  logic                        found_flag_next;
  logic [2:0][ForceW-1:0]      sum;

  assign unused_pad = '0;

  // Square the radius on each write
  always_ff @(posedge clk) begin
    if (rst) begin
      rad_sq <= nonfa_pkg::RADSQ_RESET;
    end else if (cfg_wr_en) begin
      rad_sq <= SqW'(cfg_wr_data) * SqW'(cfg_wr_data);
    end
  end

  // Handshake between queue, stage and output register
  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign q_pop    = q_valid && (!s1_valid || s1_fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd  <= q_ent.cmd;
      s1_qual <= q_ent.qual;
      s1_last <= q_ent.last;
      s1_frc  <= q_ent.frc;
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= SqW'(q_ent.diff[i]) * SqW'(q_ent.diff[i]);
      end
    end
  end

  // Compare, keep the nearest, form totals and rearm after a result
  assign d2 = DistW'(s1_sq[0]) + DistW'(s1_sq[1]) + DistW'(s1_sq[2]);

  always_comb begin
    nf_eff = node_frc;
    bd_eff = best_dist_sq;
    bf_eff = best_frc;
    fd_eff = found_flag;
    if (s1_cmd == nonfa_pkg::CMD_START) begin
      nf_eff = s1_frc;
      bd_eff = DistW'(rad_sq);
      bf_eff = '0;
      fd_eff = 1'b0;
    end else if (s1_qual && d2 < best_dist_sq) begin
      bd_eff = d2;
      bf_eff = s1_frc;
      fd_eff = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      sum[i] = nonfa_pkg::sat_add(nf_eff[i], bf_eff[i]);
    end
    if (s1_last) begin
      best_dist_sq_next = DistW'(rad_sq);
      best_frc_next     = unused_pad;
      found_flag_next   = 1'b0;
    end else begin
      best_dist_sq_next = bd_eff;
      best_frc_next     = bf_eff;
      found_flag_next   = fd_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_frc     <= '0;
      best_dist_sq <= '0;
      best_frc     <= '0;
      found_flag   <= 1'b0;
    end else if (s1_fire) begin
      node_frc     <= nf_eff;
      best_dist_sq <= best_dist_sq_next;
      best_frc     <= best_frc_next;
      found_flag   <= found_flag_next;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      total_x        <= sum[0];
      total_y        <= sum[1];
      total_z        <= sum[2];
      neighbor_found <= fd_eff;
    end
  end

  `NONFA_ASSERT_NEXT(a_back_result_out, clk, rst, s1_fire && s1_last, out_valid,
                     "last request fired without a result")
  `NONFA_ASSERT_NEXT(a_back_rearm, clk, rst, s1_fire && s1_last,
                     !found_flag && best_frc == '0, "search not rearmed after result")

endmodule

[sv/nearest_owned_neighbor_force_add.sv]
// Top level of the nearest owned neighbour force add block.
// Depends on nonfa_pkg, nonfa_front, nonfa_queue and nonfa_back.
//
// Usage:
//   Input channel (in_valid / in_stall): a start request (command 0) loads a
//   node's id, position and force; neighbour requests (command 1) follow. A
//   neighbour counts when its owner_id matches the node, it is attached and
//   active, and its squared distance is strictly below the squared radius;
//   the nearest one (earliest on a tie) supplies its force. A request with
//   last_item set produces one result: node force plus kept force per axis,
//   saturated, and neighbor_found. The search then rearms for the same node.
//   Output channel (out_valid / out_stall): one result per last request.
//   Radius port: cfg_wr_en writes cfg_wr_data; squared at the write and
//   sampled at each start or rearm. Write it only while the block is idle.
// Timing: one request per cycle sustained while out_stall is low. A last request's
//   result passes the front register, queue, squaring stage and output register.
// Reset: radius 1.0, queue emptied, node and search state cleared.
// Stall: the output register holds; the queue absorbs up to QueueDepth
//   requests behind the front register, then in_stall rises.
`timescale 1ns / 1ps

module nearest_owned_neighbor_force_add #(
  parameter int QueueDepth = nonfa_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [nonfa_pkg::RadW-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [nonfa_pkg::IdW-1:0]    owner_id,
  input  logic [nonfa_pkg::PosW-1:0]   pos_x,
  input  logic [nonfa_pkg::PosW-1:0]   pos_y,
  input  logic [nonfa_pkg::PosW-1:0]   pos_z,
  input  logic [nonfa_pkg::ForceW-1:0] force_x,
  input  logic [nonfa_pkg::ForceW-1:0] force_y,
  input  logic [nonfa_pkg::ForceW-1:0] force_z,
  input  logic                         is_attached,
  input  logic                         is_active,
  input  logic                         last_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [nonfa_pkg::ForceW-1:0] total_x,
  output logic [nonfa_pkg::ForceW-1:0] total_y,
  output logic [nonfa_pkg::ForceW-1:0] total_z,
  output logic                         neighbor_found
);

  logic              ent_valid;
  nonfa_pkg::entry_t ent;
  logic              q_full;
  logic              q_valid;
  nonfa_pkg::entry_t q_ent;
  logic              q_pop;
  logic              q_push;

  assign q_push = ent_valid && !q_full;

  // Accept and classify
  nonfa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .owner_id    (owner_id),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .force_x     (force_x),
    .force_y     (force_y),
    .force_z     (force_z),
    .is_attached (is_attached),
    .is_active   (is_active),
    .last_item   (last_item),
    .ent_valid   (ent_valid),
    .ent         (ent),
    .q_full      (q_full)
  );

  // Decouple front and back
  nonfa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (ent),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_ent    (q_ent),
    .pop      (q_pop)
  );

  // Search and emit
  nonfa_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .q_valid        (q_valid),
    .q_ent          (q_ent),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .total_x        (total_x),
    .total_y        (total_y),
    .total_z        (total_z),
    .neighbor_found (neighbor_found)
  );

endmodule
